// ----- rtl/two_class_priority_queue_assert.svh -----
// Assertion macros used by the checker file of the priority queue.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define TCPQ_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Consequence must hold in the cycle after the condition.
`define TCPQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- rtl/tcpq_pkg.sv -----
`timescale 1ns / 1ps
package tcpq_pkg;

  // Operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_SERVE  = 1'b1;

  localparam int STATUS_BITS = 3;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam status_t STATUS_ACCEPTED       = 3'd0;
  localparam status_t STATUS_DROPPED        = 3'd1;
  localparam status_t STATUS_SERVED_URGENT  = 3'd2;
  localparam status_t STATUS_SERVED_REGULAR = 3'd3;
  localparam status_t STATUS_EMPTY          = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic arrive;   // arrive transfer this cycle
    logic serve;    // serve transfer this cycle
    logic finish;   // read data of a serve is ready, load the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic urgent_busy;
    logic regular_busy;
  } sts_t;

endpackage

// ----- rtl/tcpq_req_if.sv -----
`timescale 1ns / 1ps
interface tcpq_req_if #(
  parameter int ID_BITS = 32
) ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic               urgent;
  logic [ID_BITS-1:0] item_id;

  modport source (output valid, output opcode, output urgent, output item_id, input ready);
  modport sink   (input valid, input opcode, input urgent, input item_id, output ready);
endinterface

// ----- rtl/tcpq_rsp_if.sv -----
`timescale 1ns / 1ps
interface tcpq_rsp_if import tcpq_pkg::*; #(
  parameter int ID_BITS = 32
) ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ID_BITS-1:0] served_id;

  modport source (output valid, output status, output served_id, input ready);
  modport sink   (input valid, input status, input served_id, output ready);
endinterface

// ----- rtl/tcpq_ram.sv -----
`timescale 1ns / 1ps
module tcpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tcpq_ctrl.sv -----
`timescale 1ns / 1ps
module tcpq_ctrl import tcpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_opcode,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state, state_next;
  logic valid, valid_next;
  logic accept;
  logic hit;
  logic load;

  // Take a new item only in the idle state when the result slot is free or drains now.
  assign req_ready = (state == S_IDLE) && (!valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign hit       = sts.urgent_busy || sts.regular_busy;

  assign cmd.arrive = accept && (req_opcode == OP_ARRIVE);
  assign cmd.serve  = accept && (req_opcode == OP_SERVE);
  assign cmd.finish = (state == S_READ);

  assign load      = cmd.arrive || (cmd.serve && !hit) || cmd.finish;
  assign rsp_valid = valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.serve && hit) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      valid_next = 1'b1;
    end else if (rsp_ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

endmodule

// ----- rtl/tcpq_dp.sv -----
`timescale 1ns / 1ps
module tcpq_dp import tcpq_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               urgent,
  input  logic [ID_BITS-1:0] item_id,
  output status_t            status,
  output logic [ID_BITS-1:0] served_id
);

  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef logic [ADDR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  ptr_t u_head, u_tail, r_head, r_tail;
  cnt_t u_count, r_count;
  logic pick_urgent;
  logic u_full, r_full;
  logic push_u, push_r, pop_u, pop_r;
  logic [ID_BITS-1:0] u_rdata, r_rdata;

  function automatic ptr_t advance(input ptr_t p);
    advance = (p == ptr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign u_full = (u_count == cnt_t'(DEPTH));
  assign r_full = (r_count == cnt_t'(DEPTH));

  assign sts.urgent_busy  = (u_count != '0);
  assign sts.regular_busy = (r_count != '0);

  assign push_u = cmd.arrive && urgent && !u_full;
  assign push_r = cmd.arrive && !urgent && !r_full;
  assign pop_u  = cmd.serve && sts.urgent_busy;
  assign pop_r  = cmd.serve && !sts.urgent_busy && sts.regular_busy;

  tcpq_ram #(.WIDTH(ID_BITS), .DEPTH(DEPTH)) u_urgent_ram (
    .clk   (clk),
    .we    (push_u),
    .waddr (u_tail),
    .wdata (item_id),
    .re    (pop_u),
    .raddr (u_head),
    .rdata (u_rdata)
  );

  tcpq_ram #(.WIDTH(ID_BITS), .DEPTH(DEPTH)) u_regular_ram (
    .clk   (clk),
    .we    (push_r),
    .waddr (r_tail),
    .wdata (item_id),
    .re    (pop_r),
    .raddr (r_head),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      u_head  <= '0;
      u_tail  <= '0;
      u_count <= '0;
      r_head  <= '0;
      r_tail  <= '0;
      r_count <= '0;
    end else begin
      if (push_u) begin
        u_tail  <= advance(u_tail);
        u_count <= u_count + cnt_t'(1);
      end
      if (push_r) begin
        r_tail  <= advance(r_tail);
        r_count <= r_count + cnt_t'(1);
      end
      if (pop_u) begin
        u_head  <= advance(u_head);
        u_count <= u_count - cnt_t'(1);
      end
      if (pop_r) begin
        r_head  <= advance(r_head);
        r_count <= r_count - cnt_t'(1);
      end
    end
  end

  // Result payload; the controller loads it only into a free slot.
  always_ff @(posedge clk) begin
    if (cmd.serve) begin
      pick_urgent <= sts.urgent_busy;
    end
    if (cmd.arrive) begin
      status    <= (urgent ? u_full : r_full) ? STATUS_DROPPED : STATUS_ACCEPTED;
      served_id <= '0;
    end else if (cmd.serve && !sts.urgent_busy && !sts.regular_busy) begin
      status    <= STATUS_EMPTY;
      served_id <= '0;
    end else if (cmd.finish) begin
      status    <= pick_urgent ? STATUS_SERVED_URGENT : STATUS_SERVED_REGULAR;
      served_id <= pick_urgent ? u_rdata : r_rdata;
    end
  end

endmodule

// ----- rtl/two_class_priority_queue.sv -----
`timescale 1ns / 1ps
// Strict-priority queue with an urgent and a regular FIFO of item identifiers.
// Channels: req (sink) carries opcode, urgent and item_id; rsp (source) carries
// status and served_id. Each side moves one item per transfer (valid & ready).
// An arrive appends item_id to the queue picked by urgent, or is dropped with
// status DROPPED when that queue already holds DEPTH entries. A serve pops the
// oldest urgent entry, else the oldest regular entry, else answers EMPTY.
// Every request gives exactly one response, in request order.
// Response timing: arrive and empty serve show their response in the cycle after
// the request transfer; a serve that pops passes through the read state first,
// because the queue storage has a registered read port.
// Throughput: one item per cycle for arrives and empty serves while rsp.ready is
// high; a popping serve holds req.ready low in its read state. The response
// register lets a new request in during the same cycle its previous result is
// taken; while a result waits untaken, req.ready stays low.
// Stall: rsp holds valid and payload until rsp.ready is seen.
// Reset (rst, synchronous): both queues become empty and all pointers return
// to zero; storage contents are not cleared, none is needed.
module two_class_priority_queue import tcpq_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  tcpq_req_if.sink   req,
  tcpq_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing: request admission, read wait and response valid.
  tcpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Queue pointers, counts, storage and the response payload register.
  tcpq_dp #(.DEPTH(DEPTH), .ID_BITS(ID_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .urgent    (req.urgent),
    .item_id   (req.item_id),
    .status    (rsp.status),
    .served_id (rsp.served_id)
  );

endmodule

// ----- rtl/tcpq_checker.sv -----
`timescale 1ns / 1ps
`include "two_class_priority_queue_assert.svh"
module tcpq_checker import tcpq_pkg::*; #(
  parameter int ID_BITS = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input status_t            status,
  input logic [ID_BITS-1:0] served_id
);

  logic [1:0] pending;
  logic       req_xfer, rsp_xfer;
  logic       no_pop, rsp_stall;
  logic [STATUS_BITS+ID_BITS-1:0] payload;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // Responses that carry no popped identifier.
  assign no_pop    = rsp_valid && (status == STATUS_ACCEPTED || status == STATUS_DROPPED ||
                                   status == STATUS_EMPTY);
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign payload   = {status, served_id};

  // Track requests whose response has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_xfer} - {1'b0, rsp_xfer};
    end
  end

  `TCPQ_ASSERT_NOW(a_one_in_flight, 1'b1, pending <= 2'd1, "more than one request in flight")
  `TCPQ_ASSERT_NOW(a_rsp_has_req, rsp_valid, pending == 2'd1, "response without request")
  `TCPQ_ASSERT_NOW(a_id_zero, no_pop, served_id == '0, "served_id nonzero without a pop")
  `TCPQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(payload), "rsp changed in stall")

endmodule

bind two_class_priority_queue tcpq_checker #(.ID_BITS(ID_BITS)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .served_id (rsp.served_id)
);
